// File: hw/rtl/fhct_pkg.sv
// Package: shared types and constants for the FNV hashed counting table.
`default_nettype none
package fhct_pkg;
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_COUNT_BITS = 32;
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    typedef enum logic [1:0] {
        CMD_INCR   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISS     = 2'd1,
        ST_RESERVED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic [0:0] REG_EMPTY   = 1'b0;
    localparam logic [0:0] REG_DELETED = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/fhct_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface fhct_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key;
    logic        win;
    logic [5:0]  slot_index;
    modport source (output valid, command, key, win, slot_index, input ready);
    modport sink   (input valid, command, key, win, slot_index, output ready);
endinterface

interface fhct_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] key_out;
    logic [31:0] visits;
    logic [31:0] wins;
    logic [5:0]  slot_out;
    logic [6:0]  occupancy;
    modport source (output valid, status, key_out, visits, wins, slot_out, occupancy,
                    input ready);
    modport sink   (input valid, status, key_out, visits, wins, slot_out, occupancy,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fnv_hashed_counting_table.sv
// Top level: FNV-1a hashed counting table with linear probing.
// An increment hashes the 8 key bytes (four 32x32 partial products per byte), probes
// slot by slot from the home slot and ends with an update step; a lookup does the same
// without the update; a read fetches one slot; a reserved key or unused command goes
// straight to the result. One transaction at a time, taken only in the idle state.
// Reset clears valid bits and occupancy and restores both sentinel registers.
`default_nettype none
module fnv_hashed_counting_table
    import fhct_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fhct_req_if.sink         req,
    fhct_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [OW+3:0] LIMIT = (OW+4)'(CAPACITY * 7);

    typedef enum logic [3:0] {
        S_IDLE, S_HASH_A, S_HASH_B, S_PROBE_RD, S_PROBE_CHK, S_UPD, S_READ_RD,
        S_READ_CHK, S_OUT
    } state_t;

    // slot storage
    logic [63:0]           key_mem  [CAPACITY];
    logic [COUNT_BITS-1:0] vis_mem  [CAPACITY];
    logic [COUNT_BITS-1:0] win_mem  [CAPACITY];
    logic [CAPACITY-1:0]   used_reg;

    state_t                state_reg;
    logic [63:0]           empty_reg, deleted_reg;
    logic [1:0]            cmd_reg;
    logic [63:0]           key_reg, hash_reg;
    logic                  win_reg;
    logic [2:0]            byte_reg;
    logic [1:0]            part_reg;
    logic [63:0]           acc_reg;
    logic [63:0]           prod_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW:0]           probe_reg;
    logic [OW-1:0]         occ_reg;
    logic [63:0]           rd_key_reg;
    logic [COUNT_BITS-1:0] rd_vis_reg, rd_win_reg;
    logic                  rd_used_reg;
    logic [1:0]            st_reg;
    logic [63:0]           ko_reg;
    logic [31:0]           vo_reg, wo_reg;
    logic [5:0]            so_reg;

    // config port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3])
            REG_EMPTY:   prdata = empty_reg;
            REG_DELETED: prdata = deleted_reg;
            default:     prdata = '0;
        endcase
    end

    // shared 32x32 multiplier: partial products of hash by prime
    logic [31:0] ma, mb;
    logic [63:0] mprod;
    always_comb
    begin
        case (part_reg)
            2'd0:    begin ma = hash_reg[31:0];  mb = FNV_PRIME[31:0];  end
            2'd1:    begin ma = hash_reg[63:32]; mb = FNV_PRIME[31:0];  end
            2'd2:    begin ma = hash_reg[31:0];  mb = FNV_PRIME[63:32]; end
            default: begin ma = hash_reg[63:32]; mb = FNV_PRIME[63:32]; end
        endcase
        mprod = ma * mb;
    end

    logic [COUNT_BITS-1:0] vis_new, win_new;
    logic [COUNT_BITS-1:0] vis_base, win_base;
    logic [AW-1:0] probe_pos;
    assign probe_pos = pos_reg;
    assign vis_base = rd_used_reg ? rd_vis_reg : '0;
    assign win_base = rd_used_reg ? rd_win_reg : '0;
    assign vis_new  = (vis_base == CMAX) ? CMAX : vis_base + 1'b1;
    assign win_new  = !win_reg ? win_base : ((win_base == CMAX) ? CMAX : win_base + 1'b1);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.status = st_reg;
    assign rsp.key_out = ko_reg;
    assign rsp.visits = vo_reg;
    assign rsp.wins = wo_reg;
    assign rsp.slot_out = so_reg;
    assign rsp.occupancy = 7'(occ_reg);

    // memory read/write
    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[probe_pos];
        rd_vis_reg <= vis_mem[probe_pos];
        rd_win_reg <= win_mem[probe_pos];
        if (state_reg == S_UPD && st_reg == ST_OK)
        begin
            key_mem[pos_reg] <= key_reg;
            vis_mem[pos_reg] <= vis_new;
            win_mem[pos_reg] <= win_new;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            occ_reg     <= '0;
            empty_reg   <= '0;
            deleted_reg <= '1;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[3])
                    REG_EMPTY:   empty_reg   <= pwdata;
                    REG_DELETED: deleted_reg <= pwdata;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg  <= req.command;
                        key_reg  <= req.key;
                        win_reg  <= req.win;
                        byte_reg <= '0;
                        part_reg <= '0;
                        st_reg   <= ST_MISS;
                        ko_reg   <= '0;
                        vo_reg   <= '0;
                        wo_reg   <= '0;
                        so_reg   <= '0;
                        hash_reg <= FNV_BASIS ^ {56'd0, req.key[7:0]};
                        if (req.command == CMD_READ)
                        begin
                            pos_reg   <= AW'(req.slot_index);
                            state_reg <= S_READ_RD;
                        end
                        else if (req.command == CMD_NONE)
                            state_reg <= S_OUT;
                        else if (req.key == empty_reg || req.key == deleted_reg)
                        begin
                            st_reg    <= ST_RESERVED;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            state_reg <= S_HASH_A;
                        end
                    end
                end
                // register one partial product
                S_HASH_A:
                begin
                    prod_reg  <= mprod;
                    state_reg <= S_HASH_B;
                end
                // accumulate it, mod 2^64
                S_HASH_B:
                begin
                    logic [63:0] acc_n;
                    case (part_reg)
                        2'd0:    acc_n = acc_reg + prod_reg;
                        2'd3:    acc_n = acc_reg;
                        default: acc_n = acc_reg + {prod_reg[31:0], 32'd0};
                    endcase
                    part_reg <= part_reg + 2'd1;
                    state_reg <= S_HASH_A;
                    if (part_reg == 2'd3)
                    begin
                        acc_reg <= '0;
                        byte_reg <= byte_reg + 3'd1;
                        if (byte_reg == 3'd7)
                        begin
                            pos_reg   <= acc_n[AW-1:0];
                            probe_reg <= '0;
                            state_reg <= S_PROBE_RD;
                        end
                        else
                            hash_reg <= acc_n ^ {56'd0, 8'(key_reg >> {byte_reg + 3'd1, 3'd0})};
                    end
                    else
                        acc_reg <= acc_n;
                end
                S_PROBE_RD:
                    state_reg <= S_PROBE_CHK;
                S_PROBE_CHK:
                begin
                    rd_used_reg <= used_reg[pos_reg];
                    if (!used_reg[pos_reg] || rd_key_reg == key_reg)
                    begin
                        if (cmd_reg == CMD_LOOKUP)
                        begin
                            if (used_reg[pos_reg])
                            begin
                                st_reg <= ST_OK;
                                ko_reg <= key_reg;
                                vo_reg <= 32'(rd_vis_reg);
                                wo_reg <= 32'(rd_win_reg);
                                so_reg <= 6'(pos_reg);
                            end
                            state_reg <= S_OUT;
                        end
                        else if (!used_reg[pos_reg] && ({4'd0, occ_reg} * 4'd10) > LIMIT)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            st_reg    <= ST_OK;
                            state_reg <= S_UPD;
                        end
                    end
                    else if (probe_reg == (AW+1)'(CAPACITY - 1))
                    begin
                        st_reg    <= (cmd_reg == CMD_LOOKUP) ? ST_MISS : ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_PROBE_RD;
                    end
                end
                S_UPD:
                begin
                    if (!rd_used_reg)
                        occ_reg <= occ_reg + 1'b1;
                    used_reg[pos_reg] <= 1'b1;
                    ko_reg    <= key_reg;
                    vo_reg    <= 32'(vis_new);
                    wo_reg    <= 32'(win_new);
                    so_reg    <= 6'(pos_reg);
                    state_reg <= S_OUT;
                end
                S_READ_RD:
                    state_reg <= S_READ_CHK;
                S_READ_CHK:
                begin
                    so_reg <= 6'(pos_reg);
                    if (used_reg[pos_reg])
                    begin
                        st_reg <= ST_OK;
                        ko_reg <= rd_key_reg;
                        vo_reg <= 32'(rd_vis_reg);
                        wo_reg <= 32'(rd_win_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (rsp.ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(CAPACITY)) else $error("occupancy above capacity");
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != $past(occ_reg) |-> $past(state_reg) == S_UPD)
        else $error("occupancy changed outside update");
    a_full_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.key_out == '0)
        else $error("key on failed result");
endmodule
`default_nettype wire

// File: test/fhct_checker.sv
// Checker: watches the request, result and register buses, predicts and compares results.
`timescale 1ns / 1ps
module fhct_checker
    import fhct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fhct_req_if.sink         req,
    fhct_rsp_if.sink         rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               outstanding,
    output int               errors
);
    localparam int SLOTS = DEF_CAPACITY;

    typedef struct {
        status_t     status;
        logic [63:0] key_out;
        logic [31:0] visits;
        logic [31:0] wins;
        logic [5:0]  slot_out;
        logic [6:0]  occupancy;
    } table_result_t;

    // shadow of the table and the sentinel registers
    logic        used_q   [SLOTS];
    logic [63:0] key_q    [SLOTS];
    logic [31:0] visit_q  [SLOTS];
    logic [31:0] win_q    [SLOTS];
    logic [6:0]  key_count;
    logic [63:0] empty_key;
    logic [63:0] deleted_key;

    table_result_t pending_results[$];

    function automatic logic [5:0] home_slot(input logic [63:0] k);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int b = 0; b < 8; b++)
        begin
            h = h ^ {56'd0, k[b*8 +: 8]};
            h = h * FNV_PRIME;
        end
        return h[5:0];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    // apply one transaction to the shadow table and return the expected result
    function automatic table_result_t apply_request(input logic [1:0] cmd, input logic [63:0] k,
                                                    input logic w, input logic [5:0] si);
        table_result_t r;
        logic [5:0] p;
        logic [5:0] pos;
        logic found;
        logic has_free;
        r = '{ST_MISS, 64'd0, 32'd0, 32'd0, 6'd0, 7'd0};
        found = 1'b0;
        has_free = 1'b0;
        pos = '0;
        if (cmd == CMD_READ)
        begin
            r.slot_out = si;
            if (used_q[si])
                r = '{ST_OK, key_q[si], visit_q[si], win_q[si], si, 7'd0};
        end
        else if (cmd == CMD_NONE)
        begin
        end
        else if (k == empty_key || k == deleted_key)
            r.status = ST_RESERVED;
        else
        begin
            // linear probe from the home slot
            for (int i = 0; i < SLOTS; i++)
            begin
                p = home_slot(k) + i[5:0];
                if (!used_q[p])
                begin
                    pos = p;
                    has_free = 1'b1;
                    break;
                end
                if (key_q[p] == k)
                begin
                    pos = p;
                    found = 1'b1;
                    break;
                end
            end
            if (cmd == CMD_LOOKUP)
            begin
                if (found)
                    r = '{ST_OK, k, visit_q[pos], win_q[pos], pos, 7'd0};
            end
            else if (!found && (int'(key_count) * 10 > SLOTS * 7 || !has_free))
                r.status = ST_FULL;
            else
            begin
                if (!found)
                begin
                    used_q[pos] = 1'b1;
                    key_q[pos] = k;
                    visit_q[pos] = '0;
                    win_q[pos] = '0;
                    key_count = key_count + 7'd1;
                end
                visit_q[pos] = sat_inc(visit_q[pos]);
                if (w)
                    win_q[pos] = sat_inc(win_q[pos]);
                r = '{ST_OK, k, visit_q[pos], win_q[pos], pos, 7'd0};
            end
        end
        r.occupancy = key_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                used_q[i] = 1'b0;
            key_count   = '0;
            empty_key   = '0;
            deleted_key = '1;
            pending_results.delete();
            outstanding <= 0;
            errors      = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_DELETED)
                    deleted_key = pwdata;
                else
                    empty_key = pwdata;
            end
            // accepted request
            if (req.valid && req.ready)
                pending_results.push_back(apply_request(req.command, req.key, req.win,
                                                        req.slot_index));
            // accepted result
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    errors = errors + 1;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        errors = errors + 1;
                    end
                    if (rsp.key_out !== e.key_out)
                    begin
                        $error("key_out: expected %h, got %h", e.key_out, rsp.key_out);
                        errors = errors + 1;
                    end
                    if (rsp.visits !== e.visits)
                    begin
                        $error("visits: expected %0d, got %0d", e.visits, rsp.visits);
                        errors = errors + 1;
                    end
                    if (rsp.wins !== e.wins)
                    begin
                        $error("wins: expected %0d, got %0d", e.wins, rsp.wins);
                        errors = errors + 1;
                    end
                    if (rsp.slot_out !== e.slot_out)
                    begin
                        $error("slot_out: expected %0d, got %0d", e.slot_out, rsp.slot_out);
                        errors = errors + 1;
                    end
                    if (rsp.occupancy !== e.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", e.occupancy,
                               rsp.occupancy);
                        errors = errors + 1;
                    end
                end
            end
            outstanding <= pending_results.size();
        end
    end
endmodule

// File: test/fnv_hashed_counting_table_test.sv
// Testbench top: clock, reset, stimulus and register writes for the hashed counting table.
`timescale 1ns / 1ps
module fnv_hashed_counting_table_test;
    import fhct_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          outstanding;
    int          errors;

    logic [63:0] key_pool[48];
    int          sent;
    int          pool_size;
    bit          quiet;
    int          ready_hold;

    fhct_req_if req ();
    fhct_rsp_if rsp ();

    fnv_hashed_counting_table DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fhct_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .outstanding(outstanding), .errors(errors)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: ready stalls in random bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rsp.ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end
        else
            rsp.ready <= 1'b1;
    end

    // one register write: setup then access, then idle
    task automatic write_sentinel(input logic [0:0] reg_index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back and the block has settled
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || req.valid && !req.ready);
        repeat (200) @(posedge clk);
    endtask

    task automatic send(input cmd_t cmd, input logic [63:0] k, input logic w,
                        input logic [5:0] si);
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.key        <= k;
        req.win        <= w;
        req.slot_index <= si;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic random_item();
        int pick;
        logic [63:0] k;
        pick = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, pool_size - 1)];
        if (pick < 4)
            k = {$urandom, $urandom};
        else if (pick < 6)
            k = $urandom_range(0, 1) ? scoreboard.empty_key : scoreboard.deleted_key;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send(CMD_INCR, k, $urandom_range(0, 1), 6'($urandom));
        else if (pick < 80)
            send(CMD_LOOKUP, k, $urandom_range(0, 1), 6'($urandom));
        else if (pick < 97)
            send(CMD_READ, {$urandom, $urandom}, $urandom_range(0, 1), 6'($urandom));
        else
            send(CMD_NONE, k, $urandom_range(0, 1), 6'($urandom));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req.valid      = 1'b0;
        req.command    = CMD_INCR;
        req.key        = '0;
        req.win        = 1'b0;
        req.slot_index = '0;
        rsp.ready      = 1'b0;
        ready_hold     = 0;
        quiet          = 1'b0;
        sent           = 0;
        for (int i = 0; i < 48; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'd1;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reserved keys, misses, empty slot, unused command, hits
        send(CMD_INCR, 64'd0, 1'b1, 6'd0);
        send(CMD_INCR, '1, 1'b0, 6'd0);
        send(CMD_LOOKUP, '1, 1'b0, 6'd0);
        send(CMD_LOOKUP, key_pool[0], 1'b0, 6'd0);
        send(CMD_READ, '0, 1'b0, 6'd63);
        send(CMD_READ, '0, 1'b0, 6'd0);
        send(CMD_NONE, key_pool[2], 1'b1, 6'd5);
        send(CMD_INCR, key_pool[0], 1'b1, 6'd0);
        send(CMD_INCR, key_pool[0], 1'b0, 6'd0);
        send(CMD_INCR, key_pool[1], 1'b1, 6'd0);
        send(CMD_LOOKUP, key_pool[0], 1'b0, 6'd0);
        send(CMD_LOOKUP, key_pool[1], 1'b0, 6'd0);
        for (int s = 0; s < 64; s += 9)
            send(CMD_READ, '0, 1'b0, s[5:0]);

        // random phases, each under its own pair of sentinels
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0: begin write_sentinel(REG_EMPTY, key_pool[3]);
                         write_sentinel(REG_DELETED, key_pool[0]); end
                1: begin write_sentinel(REG_EMPTY, '1);
                         write_sentinel(REG_DELETED, '0); end
                2: begin write_sentinel(REG_EMPTY, {$urandom, $urandom});
                         write_sentinel(REG_DELETED, key_pool[5]); end
                default: begin write_sentinel(REG_EMPTY, '0);
                               write_sentinel(REG_DELETED, '1); end
            endcase
            pool_size = (ph == 0) ? 20 : 48;
            for (int n = 0; n < 370; n++)
            begin
                if (ph == 3 && n >= 220)
                    quiet = 1'b1;
                if (ph == 1 && n == 100)
                    drain();
                random_item();
            end
        end
        req.valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d transactions over four sentinel settings, table filled to %0d keys.",
                 sent, scoreboard.key_count);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/fhct_pkg.sv
hw/rtl/fhct_if.sv
hw/rtl/fnv_hashed_counting_table.sv
test/fhct_checker.sv
test/fnv_hashed_counting_table_test.sv
